// File: hw/rtl/vqp_pkg.sv
// Shared types and constants for the split virtqueue producer.
// Holds the configuration view, the front-to-back command and result records.
// No dependencies.
`default_nettype none

package vqp_pkg;

  // Offset width covering descriptor table plus avail ring for any queue size
  // and page alignment this block supports
  localparam int unsigned OFF_W = 21;

  // Command queue between front and back
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RING_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QSIZE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEGACY     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_NUM  = 2'd3;
  localparam logic [3:0]           QSIZE_LOG2_RST = 4'd8;

  // Request modes and result kinds
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_COMMIT = 1'b1;
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_NOTIFY = 1'b1;

  // Memory write sizes
  localparam logic [3:0] BYTES_WORD = 4'd8;
  localparam logic [3:0] BYTES_HALF = 4'd2;
  localparam logic [3:0] BYTES_NONE = 4'd0;

  // Offsets inside the ring structures
  localparam int unsigned DESC_WORD1_OFF = 8;
  localparam int unsigned AVAIL_IDX_OFF  = 2;
  localparam int unsigned AVAIL_RING_OFF = 4;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 152;

  typedef struct packed {
    logic [63:0] ring_base;
    logic [3:0]  qsize_log2;
    logic        legacy_layout;
    logic [15:0] queue_number;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] buf_addr;
    logic [31:0] buf_len;
    logic        device_writes;
    logic        end_of_chain;
    logic        used_no_notify;
  } item_t;

  // One classified request, expanded into results by the back end
  typedef struct packed {
    logic             is_add;
    logic [63:0]      buf_addr;
    logic [63:0]      desc_word;
    logic [OFF_W-1:0] desc_off;
    logic             has_short;
    logic [OFF_W-1:0] short_off;
    logic [15:0]      short_data;
    logic             has_notify;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] write_addr;
    logic [63:0] write_data;
    logic [3:0]  write_bytes;
    logic [15:0] notify_queue;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/virtqueue_split_ring_producer.sv
// Split virtqueue producer, driver side: front end, command queue, back end.
// A request passes through the command queue; its results leave from the output
// register, one per cycle while the result port is ready. An add gives two results,
// a chain-closing add three, a commit one or two (two unless used_no_notify).
// Reset: ring indices and counts clear, registers take their reset values;
// there is no clearing pass. Depends on vqp_pkg, vqp_front, vqp_fifo, vqp_back.
`default_nettype none

module virtqueue_split_ring_producer #(
  parameter int unsigned MAX_QUEUE_SIZE = 256,
  parameter int unsigned LEGACY_ALIGN   = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [vqp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [63:0]                       cfg_wdata_i,
  // Requests
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // buf_addr[63:0], buf_len[95:64], device_writes[96], used_no_notify[97], zero pad
  input  wire logic [vqp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // end_of_chain
  input  wire logic                              s_axis_tlast,
  // mode
  input  wire logic                              s_axis_tuser,
  // Results
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // write_addr[63:0], write_data[127:64], write_bytes[131:128],
  // notify_queue[147:132], zero pad
  output logic [vqp_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // last
  output logic                                   m_axis_tlast,
  // kind
  output logic                                   m_axis_tuser
);

  vqp_pkg::cfg_t  cfg_q, cfg_d;
  vqp_pkg::item_t item;
  vqp_pkg::cmd_t  push_cmd;
  vqp_pkg::cmd_t  head_cmd;
  vqp_pkg::res_t  res;
  logic           cmd_full;
  logic           cmd_push;
  logic           cmd_valid;
  logic           cmd_pop;

  // Write configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vqp_pkg::REG_RING_BASE:  cfg_d.ring_base     = cfg_wdata_i;
        vqp_pkg::REG_QSIZE_LOG2: cfg_d.qsize_log2    = cfg_wdata_i[3:0];
        vqp_pkg::REG_LEGACY:     cfg_d.legacy_layout = cfg_wdata_i[0];
        vqp_pkg::REG_QUEUE_NUM:  cfg_d.queue_number  = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ring_base: '0, qsize_log2: vqp_pkg::QSIZE_LOG2_RST,
                 legacy_layout: 1'b0, queue_number: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Unpack the request
  assign item.mode           = s_axis_tuser;
  assign item.buf_addr       = s_axis_tdata[63:0];
  assign item.buf_len        = s_axis_tdata[95:64];
  assign item.device_writes  = s_axis_tdata[96];
  assign item.end_of_chain   = s_axis_tlast;
  assign item.used_no_notify = s_axis_tdata[97];

  vqp_front #(
    .MAX_QUEUE_SIZE (MAX_QUEUE_SIZE),
    .LEGACY_ALIGN   (LEGACY_ALIGN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (push_cmd)
  );

  vqp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (push_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd)
  );

  vqp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result
  assign m_axis_tdata = {4'b0, res.notify_queue, res.write_bytes, res.write_data,
                         res.write_addr};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.kind;

  // A notification always closes its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == vqp_pkg::KIND_NOTIFY) |-> m_axis_tlast)
    else $error("notification not marked last");

  // A 2-byte write carries only a 16-bit value and no queue index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == vqp_pkg::KIND_WRITE) &&
    (m_axis_tdata[131:128] == vqp_pkg::BYTES_HALF)
    |-> (m_axis_tdata[127:80] == '0) && (m_axis_tdata[147:132] == '0))
    else $error("short write carries stray bits");

  // A taken result that is not last is followed at once by the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("request results interrupted");

  // Requests are refused only while the command queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |-> cmd_full && !$stable(cmd_full) || cmd_full)
    else $error("request refused with room in queue");

endmodule

`default_nettype wire

// File: hw/rtl/vqp_fifo.sv
// Two-entry command queue between the producer front and back ends.
// Depends on vqp_pkg for the command record and depth.
`default_nettype none

module vqp_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  vqp_pkg::cmd_t      cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output vqp_pkg::cmd_t      cmd_o
);

  vqp_pkg::cmd_t                     mem_q [vqp_pkg::CMD_DEPTH];
  logic [vqp_pkg::CMD_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [vqp_pkg::CMD_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [vqp_pkg::CMD_CNT_W-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == vqp_pkg::CMD_CNT_W'(vqp_pkg::CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == vqp_pkg::CMD_PTR_W'(vqp_pkg::CMD_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == vqp_pkg::CMD_PTR_W'(vqp_pkg::CMD_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vqp_front.sv
// Front end of the split virtqueue producer: accepts requests, keeps the ring
// indices and turns each request into one command. Depends on vqp_pkg.
`default_nettype none

module vqp_front #(
  parameter int unsigned MAX_QUEUE_SIZE = 256,
  parameter int unsigned LEGACY_ALIGN   = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  vqp_pkg::cfg_t      cfg_i,
  input  wire logic          item_valid_i,
  output logic               item_ready_o,
  input  vqp_pkg::item_t     item_i,
  input  wire logic          cmd_full_i,
  output logic               cmd_push_o,
  output vqp_pkg::cmd_t      cmd_o
);

  localparam int unsigned MAX_LOG2 = $clog2(MAX_QUEUE_SIZE);
  localparam int unsigned IDX_W    = (MAX_LOG2 < 1) ? 1 : MAX_LOG2;
  localparam int unsigned LOG_W    = $clog2(MAX_LOG2 + 1);
  localparam int unsigned OFF_W    = vqp_pkg::OFF_W;

  logic [IDX_W-1:0] next_free_q, next_free_d;
  logic [IDX_W-1:0] chain_head_q, chain_head_d;
  logic             chain_open_q, chain_open_d;
  logic [15:0]      pending_q, pending_d;
  logic [15:0]      published_q, published_d;

  logic [OFF_W-1:0] off_plain [MAX_LOG2+1];
  logic [OFF_W-1:0] off_legacy [MAX_LOG2+1];

  logic [LOG_W-1:0] eff_log2;
  logic [IDX_W:0]   qsize;
  logic [IDX_W-1:0] qmask;
  logic [OFF_W-1:0] avail_off;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] link;
  logic [IDX_W-1:0] head;
  logic [15:0]      slot_sum;
  logic [IDX_W-1:0] slot;
  logic [15:0]      pub_new;

  // Avail ring offset per queue size, plain and rounded up to the legacy page
  for (genvar k = 0; k <= MAX_LOG2; k++) begin : g_off
    localparam int unsigned PLAIN  = 16 << k;
    localparam int unsigned LEGACY = ((PLAIN + LEGACY_ALIGN - 1) / LEGACY_ALIGN) * LEGACY_ALIGN;
    assign off_plain[k]  = OFF_W'(PLAIN);
    assign off_legacy[k] = OFF_W'(LEGACY);
  end

  // Effective queue size, capped at the largest supported size
  assign eff_log2  = (cfg_i.qsize_log2 > 4'(MAX_LOG2)) ? LOG_W'(MAX_LOG2)
                                                       : LOG_W'(cfg_i.qsize_log2);
  assign qsize     = (IDX_W+1)'(1) << eff_log2;
  assign qmask     = IDX_W'(qsize - 1'b1);
  assign avail_off = cfg_i.legacy_layout ? off_legacy[eff_log2] : off_plain[eff_log2];

  // Ring indices reduced to the current queue size
  assign idx      = next_free_q & qmask;
  assign link     = (idx + 1'b1) & qmask;
  assign head     = (chain_open_q ? chain_head_q : idx) & qmask;
  assign slot_sum = published_q + pending_q;
  assign slot     = slot_sum[IDX_W-1:0] & qmask;
  assign pub_new  = published_q + pending_q;

  assign item_ready_o = !cmd_full_i;
  assign cmd_push_o   = item_valid_i && !cmd_full_i;

  // Classify the request into a command
  always_comb begin
    cmd_o            = '0;
    cmd_o.buf_addr   = item_i.buf_addr;
    cmd_o.desc_word  = {16'(link), 14'b0, item_i.device_writes, !item_i.end_of_chain,
                        item_i.buf_len};
    cmd_o.desc_off   = OFF_W'({idx, 4'b0});
    unique case (item_i.mode)
      vqp_pkg::MODE_ADD: begin
        cmd_o.is_add     = 1'b1;
        cmd_o.has_short  = item_i.end_of_chain;
        cmd_o.short_off  = avail_off + OFF_W'(vqp_pkg::AVAIL_RING_OFF) + OFF_W'({slot, 1'b0});
        cmd_o.short_data = 16'(head);
        cmd_o.has_notify = 1'b0;
      end
      vqp_pkg::MODE_COMMIT: begin
        cmd_o.is_add     = 1'b0;
        cmd_o.has_short  = 1'b1;
        cmd_o.short_off  = avail_off + OFF_W'(vqp_pkg::AVAIL_IDX_OFF);
        cmd_o.short_data = pub_new;
        cmd_o.has_notify = !item_i.used_no_notify;
      end
      default: ;
    endcase
  end

  // Update ring state on each accepted request
  always_comb begin
    next_free_d  = next_free_q;
    chain_head_d = chain_head_q;
    chain_open_d = chain_open_q;
    pending_d    = pending_q;
    published_d  = published_q;
    if (cmd_push_o) begin
      if (item_i.mode == vqp_pkg::MODE_ADD) begin
        next_free_d = link;
        if (!chain_open_q) begin
          chain_head_d = idx;
        end
        if (item_i.end_of_chain) begin
          chain_open_d = 1'b0;
          pending_d    = pending_q + 1'b1;
        end else begin
          chain_open_d = 1'b1;
        end
      end else begin
        published_d = pub_new;
        pending_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q  <= '0;
      chain_head_q <= '0;
      chain_open_q <= 1'b0;
      pending_q    <= '0;
      published_q  <= '0;
    end else begin
      next_free_q  <= next_free_d;
      chain_head_q <= chain_head_d;
      chain_open_q <= chain_open_d;
      pending_q    <= pending_d;
      published_q  <= published_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vqp_back.sv
// Back end of the split virtqueue producer: expands each command into memory writes
// and maybe a notification, one result per cycle unless stalled. Depends on vqp_pkg.
`default_nettype none

module vqp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  vqp_pkg::cfg_t      cfg_i,
  input  wire logic          cmd_valid_i,
  input  vqp_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output vqp_pkg::res_t      res_o
);

  localparam logic [1:0] PH_DESC0  = 2'd0;
  localparam logic [1:0] PH_DESC1  = 2'd1;
  localparam logic [1:0] PH_SHORT  = 2'd2;
  localparam logic [1:0] PH_NOTIFY = 2'd3;

  logic [1:0]    phase_q, phase_d;
  logic          mid_q, mid_d;
  logic          out_valid_q, out_valid_d;
  vqp_pkg::res_t res_q, res_d;

  logic [1:0]                 cur_phase;
  logic [1:0]                 nxt_phase;
  logic                       has_next;
  logic                       load;
  logic [vqp_pkg::OFF_W-1:0]  beat_off;

  assign cur_phase = mid_q ? phase_q : (cmd_i.is_add ? PH_DESC0 : PH_SHORT);
  assign load      = cmd_valid_i && (!out_valid_q || res_ready_i);
  assign cmd_pop_o = load && !has_next;

  // Pick the following result of this command
  always_comb begin
    nxt_phase = PH_DESC0;
    has_next  = 1'b0;
    unique case (cur_phase)
      PH_DESC0: begin
        nxt_phase = PH_DESC1;
        has_next  = 1'b1;
      end
      PH_DESC1: begin
        nxt_phase = PH_SHORT;
        has_next  = cmd_i.has_short;
      end
      PH_SHORT: begin
        nxt_phase = PH_NOTIFY;
        has_next  = cmd_i.has_notify;
      end
      PH_NOTIFY: begin
        nxt_phase = PH_DESC0;
        has_next  = 1'b0;
      end
      default: ;
    endcase
  end

  // Build the current result
  always_comb begin
    beat_off = '0;
    res_d    = res_q;
    if (load) begin
      res_d      = '0;
      res_d.last = !has_next;
      unique case (cur_phase)
        PH_DESC0: begin
          beat_off          = cmd_i.desc_off;
          res_d.write_data  = cmd_i.buf_addr;
          res_d.write_bytes = vqp_pkg::BYTES_WORD;
        end
        PH_DESC1: begin
          beat_off          = cmd_i.desc_off | vqp_pkg::OFF_W'(vqp_pkg::DESC_WORD1_OFF);
          res_d.write_data  = cmd_i.desc_word;
          res_d.write_bytes = vqp_pkg::BYTES_WORD;
        end
        PH_SHORT: begin
          beat_off          = cmd_i.short_off;
          res_d.write_data  = 64'(cmd_i.short_data);
          res_d.write_bytes = vqp_pkg::BYTES_HALF;
        end
        PH_NOTIFY: begin
          res_d.write_bytes  = vqp_pkg::BYTES_NONE;
        end
        default: ;
      endcase
      if (cur_phase == PH_NOTIFY) begin
        res_d.kind         = vqp_pkg::KIND_NOTIFY;
        res_d.notify_queue = cfg_i.queue_number;
      end else begin
        res_d.kind       = vqp_pkg::KIND_WRITE;
        res_d.write_addr = cfg_i.ring_base + 64'(beat_off);
      end
    end
  end

  // Advance through the command and hold the output register
  always_comb begin
    phase_d     = phase_q;
    mid_d       = mid_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      mid_d       = has_next;
      phase_d     = nxt_phase;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DESC0;
      mid_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mid_q       <= mid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
